// ----- src/rpra_pkg.sv -----
// Package for the redundant pair role arbiter: event and command codes,
// item, result and configuration structs, and the tie-break table.
// Depends on nothing; rpra_state and the top level import it.
package rpra_pkg;

    // event kinds carried in s_tuser
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_SYNC  = 3'd1;
    localparam logic [2:0] KIND_PEER  = 3'd2;
    localparam logic [2:0] KIND_FAULT = 3'd3;
    localparam logic [2:0] KIND_QUIT  = 3'd4;

    // handover commands
    localparam logic [2:0] CMD_OK             = 3'd0;
    localparam logic [2:0] CMD_START_MAIN     = 3'd1;
    localparam logic [2:0] CMD_SWITCHED_MAIN  = 3'd2;
    localparam logic [2:0] CMD_START_SLAVE    = 3'd3;
    localparam logic [2:0] CMD_SWITCHED_SLAVE = 3'd4;

    // unit numbers
    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_ONE  = 2'd1;
    localparam logic [1:0] UNIT_TWO  = 2'd2;
    localparam logic [1:0] UNIT_KEEP = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_OWN_UNIT        = 3'd0;
    localparam logic [2:0] CFG_FAULT_SWITCH_EN = 3'd1;
    localparam logic [2:0] CFG_PARTNER_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_PEER_TIMEOUT    = 3'd3;
    localparam logic [2:0] CFG_INIT_WAIT       = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] peer_index;
        logic [2:0] partner_command;
        logic [1:0] partner_main;
    } item_t;

    typedef struct packed {
        logic       is_main;
        logic [1:0] main_unit;
        logic [2:0] handover_state;
        logic [5:0] alive_mask;
        logic       role_set;
        logic       send_sync;
    } result_t;

    typedef struct packed {
        logic [1:0] own_unit;
        logic       fault_switch_enable;
        logic [7:0] partner_timeout;
        logic [7:0] peer_timeout;
        logic [7:0] init_wait;
    } cfg_t;

    // tie-break: bit 2 says apply, bits 1:0 give the new main unit
    function automatic logic [2:0] tie_lookup(input logic own_two, input logic [1:0] believed,
                                              input logic [1:0] partner);
        logic [3:0] key;
        logic [2:0] entry;
        key = {believed, partner};
        entry = 3'b000;
        if (!own_two) begin
            case (key)
                4'b0000: entry = 3'b101;
                4'b0001: entry = 3'b110;
                4'b0010: entry = 3'b110;
                4'b0100: entry = 3'b001;
                4'b0101: entry = 3'b001;
                4'b0110: entry = 3'b001;
                4'b1000: entry = 3'b101;
                4'b1001: entry = 3'b101;
                4'b1010: entry = 3'b010;
                default: entry = 3'b000;
            endcase
        end else begin
            case (key)
                4'b0000: entry = 3'b101;
                4'b0001: entry = 3'b101;
                4'b0010: entry = 3'b101;
                4'b0100: entry = 3'b110;
                4'b0101: entry = 3'b001;
                4'b0110: entry = 3'b001;
                4'b1000: entry = 3'b010;
                4'b1001: entry = 3'b101;
                4'b1010: entry = 3'b010;
                default: entry = 3'b000;
            endcase
        end
        return entry;
    endfunction

endpackage

// ----- src/rpra_state.sv -----
// Role state, watchdog counters and the per-event next-state logic.
// Depends on rpra_pkg; instantiated by redundant_pair_role_arbiter_unit.
module rpra_state
    import rpra_pkg::*;
#(
    parameter int NUM_PEERS  = 5,
    parameter int COUNT_BITS = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CMP_W = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [1:0]            believed_main_reg, believed_main_next;
    logic [2:0]            handover_cmd_reg, handover_cmd_next;
    logic                  main_flag_reg, main_flag_next;
    logic                  partner_alive_reg, partner_alive_next;
    logic [COUNT_BITS-1:0] partner_count_reg, partner_count_next;
    logic                  peer_alive_reg [NUM_PEERS];
    logic                  peer_alive_next [NUM_PEERS];
    logic [COUNT_BITS-1:0] peer_count_reg [NUM_PEERS];
    logic [COUNT_BITS-1:0] peer_count_next [NUM_PEERS];
    logic [COUNT_BITS-1:0] start_count_reg, start_count_next;

    logic       own_two;
    logic [1:0] me;
    logic [1:0] other;
    logic       set;
    logic       sync;
    logic [CMP_W-1:0] start_plus;
    logic [2:0] tie;
    logic       was_other;
    logic       was_main;
    logic [5:0] mask;

    function automatic logic [COUNT_BITS-1:0] load_count(input logic [7:0] t);
        logic [CMP_W-1:0] te;
        te = CMP_W'(t);
        if (te > CMP_W'(COUNT_MAX))
            return COUNT_MAX;
        else
            return COUNT_BITS'(te);
    endfunction

    assign own_two = (cfg.own_unit == UNIT_TWO);
    assign me      = own_two ? UNIT_TWO : UNIT_ONE;
    assign other   = own_two ? UNIT_ONE : UNIT_TWO;
    assign tie     = tie_lookup(own_two, believed_main_reg, item.partner_main);

    always_comb
    begin
        believed_main_next = believed_main_reg;
        handover_cmd_next  = handover_cmd_reg;
        main_flag_next     = main_flag_reg;
        partner_alive_next = partner_alive_reg;
        partner_count_next = partner_count_reg;
        start_count_next   = start_count_reg;
        for (int i = 0; i < NUM_PEERS; i++)
        begin
            peer_alive_next[i] = peer_alive_reg[i];
            peer_count_next[i] = peer_count_reg[i];
        end
        set        = 1'b0;
        sync       = 1'b0;
        start_plus = CMP_W'(start_count_reg) + CMP_W'(1);
        was_other  = (believed_main_reg != me);
        was_main   = (believed_main_reg == me);

        case (item.kind)
            KIND_TICK:
            begin
                sync = 1'b1;
                for (int i = 0; i < NUM_PEERS; i++)
                begin
                    if (peer_count_reg[i] != '0)
                    begin
                        peer_alive_next[i] = 1'b1;
                        peer_count_next[i] = peer_count_reg[i] - COUNT_ONE;
                    end
                    else
                    begin
                        peer_alive_next[i] = 1'b0;
                    end
                end
                if (partner_count_reg != '0)
                begin
                    partner_alive_next = 1'b1;
                    partner_count_next = partner_count_reg - COUNT_ONE;
                end
                else if (partner_alive_reg)
                begin
                    // partner lost: take over
                    partner_alive_next = 1'b0;
                    if (believed_main_reg != me)
                    begin
                        believed_main_next = me;
                        main_flag_next     = 1'b1;
                        set                = 1'b1;
                    end
                    handover_cmd_next = CMD_OK;
                end
                if (start_count_reg != '0)
                begin
                    if (start_plus > CMP_W'(cfg.init_wait) || start_count_reg == COUNT_MAX)
                    begin
                        // start-up wait over: choose the initial role
                        if (!partner_alive_next)
                        begin
                            believed_main_next = me;
                            main_flag_next     = 1'b1;
                        end
                        else
                        begin
                            believed_main_next = other;
                            main_flag_next     = 1'b0;
                        end
                        handover_cmd_next = CMD_OK;
                        start_count_next  = '0;
                        set               = 1'b1;
                    end
                    else
                    begin
                        start_count_next = COUNT_BITS'(start_plus);
                    end
                end
            end
            KIND_SYNC:
            begin
                partner_count_next = load_count(cfg.partner_timeout);
                if (handover_cmd_reg != CMD_OK || item.partner_command != CMD_OK)
                begin
                    case (item.partner_command)
                        CMD_START_MAIN:
                        begin
                            if (item.partner_main != UNIT_KEEP)
                                believed_main_next = item.partner_main;
                            handover_cmd_next = CMD_SWITCHED_MAIN;
                            if (was_other)
                            begin
                                main_flag_next = 1'b1;
                                set            = 1'b1;
                            end
                        end
                        CMD_SWITCHED_MAIN:
                        begin
                            if (item.partner_main == other)
                                handover_cmd_next = CMD_OK;
                        end
                        CMD_START_SLAVE:
                        begin
                            believed_main_next = other;
                            handover_cmd_next  = CMD_SWITCHED_SLAVE;
                            if (was_main)
                            begin
                                main_flag_next = 1'b0;
                                set            = 1'b1;
                            end
                        end
                        CMD_SWITCHED_SLAVE:
                        begin
                            if (item.partner_main != UNIT_KEEP)
                                believed_main_next = item.partner_main;
                            handover_cmd_next = CMD_OK;
                            main_flag_next    = 1'b1;
                            set               = 1'b1;
                        end
                        CMD_OK:
                        begin
                            if (handover_cmd_reg != CMD_START_MAIN &&
                                handover_cmd_reg != CMD_START_SLAVE)
                                handover_cmd_next = CMD_OK;
                        end
                        default:
                        begin
                            handover_cmd_next = handover_cmd_reg;
                        end
                    endcase
                end
                else if (item.partner_main != UNIT_KEEP && believed_main_reg != UNIT_KEEP)
                begin
                    // both sides idle: resolve through the tie-break table
                    if (tie[2] && start_count_reg == '0)
                    begin
                        believed_main_next = tie[1:0];
                        main_flag_next     = (tie[1:0] == me);
                        set                = 1'b1;
                    end
                end
            end
            KIND_PEER:
            begin
                for (int i = 0; i < NUM_PEERS; i++)
                begin
                    if (item.peer_index == 3'(i))
                        peer_count_next[i] = load_count(cfg.peer_timeout);
                end
            end
            KIND_FAULT:
            begin
                if (main_flag_reg && partner_alive_reg && cfg.fault_switch_enable)
                begin
                    believed_main_next = other;
                    handover_cmd_next  = CMD_SWITCHED_SLAVE;
                    main_flag_next     = 1'b0;
                    set                = 1'b1;
                    sync               = 1'b1;
                end
            end
            KIND_QUIT:
            begin
                if (main_flag_reg)
                begin
                    believed_main_next = other;
                    handover_cmd_next  = CMD_SWITCHED_SLAVE;
                    main_flag_next     = 1'b0;
                    set                = 1'b1;
                    sync               = 1'b1;
                end
            end
            default:
            begin
                set = 1'b0;
            end
        endcase

        mask    = 6'b0;
        mask[0] = partner_alive_next;
        for (int i = 0; i < NUM_PEERS && i < 5; i++)
            mask[i + 1] = peer_alive_next[i];
    end

    assign result.is_main        = main_flag_next;
    assign result.main_unit      = believed_main_next;
    assign result.handover_state = handover_cmd_next;
    assign result.alive_mask     = mask;
    assign result.role_set       = set;
    assign result.send_sync      = sync;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            believed_main_reg <= UNIT_NONE;
            handover_cmd_reg  <= CMD_OK;
            main_flag_reg     <= 1'b0;
            partner_alive_reg <= 1'b0;
            partner_count_reg <= '0;
            start_count_reg   <= COUNT_ONE;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                peer_alive_reg[i] <= 1'b0;
                peer_count_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            believed_main_reg <= believed_main_next;
            handover_cmd_reg  <= handover_cmd_next;
            main_flag_reg     <= main_flag_next;
            partner_alive_reg <= partner_alive_next;
            partner_count_reg <= partner_count_next;
            start_count_reg   <= start_count_next;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                peer_alive_reg[i] <= peer_alive_next[i];
                peer_count_reg[i] <= peer_count_next[i];
            end
        end
    end

endmodule

// ----- src/redundant_pair_role_arbiter_unit.sv -----
// Top level of the redundant pair role arbiter: stream ports, configuration
// registers, input register and result register. Depends on rpra_pkg, rpra_state.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tuser kind, s_tdata event fields
//  m_      | out       | m_tvalid/m_tready  | m_tdata role, handover and alive status
//  cfg_    | in        | cfg_we (no ready)  | cfg_index, cfg_data
//
// One event per cycle while m_ does not stall; an event waits in the input register and
// then leaves through the result register, so both registers lie between a transaction and
// its result. The role state updates as the event moves into the result register.
// A stalled m_ side holds the result; one more event waits in the input register.
// Reset clears valid flags, role state and watchdog counters, and sets configuration defaults.
module redundant_pair_role_arbiter_unit
    import rpra_pkg::*;
#(
    parameter int NUM_PEERS  = 5,
    parameter int COUNT_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] peer_index, [5:3] partner_command, [7:6] partner_main
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] is_main, [2:1] main_unit, [5:3] handover_state,
                                   // [11:6] alive_mask, [12] role_set, [13] send_sync
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;
    logic    step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_unit            <= UNIT_ONE;
            cfg_reg.fault_switch_enable <= 1'b1;
            cfg_reg.partner_timeout     <= 8'd6;
            cfg_reg.peer_timeout        <= 8'd6;
            cfg_reg.init_wait           <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_UNIT:        cfg_reg.own_unit            <= cfg_data[1:0];
                CFG_FAULT_SWITCH_EN: cfg_reg.fault_switch_enable <= cfg_data[0];
                CFG_PARTNER_TIMEOUT: cfg_reg.partner_timeout     <= cfg_data;
                CFG_PEER_TIMEOUT:    cfg_reg.peer_timeout        <= cfg_data;
                CFG_INIT_WAIT:       cfg_reg.init_wait           <= cfg_data;
                default:             cfg_reg.init_wait           <= cfg_reg.init_wait;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.kind            <= s_tuser;
            in_item_reg.peer_index      <= s_tdata[2:0];
            in_item_reg.partner_command <= s_tdata[5:3];
            in_item_reg.partner_main    <= s_tdata[7:6];
        end
        if (step)
            out_reg <= result;
    end

    rpra_state #(
        .NUM_PEERS  (NUM_PEERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.send_sync, out_reg.role_set, out_reg.alive_mask,
                       out_reg.handover_state, out_reg.main_unit, out_reg.is_main};

endmodule

// ----- src/rpra_checker.sv -----
// Port-level checks for redundant_pair_role_arbiter_unit, with the bind
// that attaches them. Depends on the top level's port list only.
module rpra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // hold an offered event until its transaction
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("offered event changed before its transaction");

    // own handover command only rests at ok, switched main or switched slave
    a_handover_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[3] && !(m_tdata[4] && m_tdata[5]))
        else $error("handover state outside its resting codes");

    a_main_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] != 2'd3)
        else $error("main unit holds an invalid number");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind redundant_pair_role_arbiter_unit rpra_checker u_rpra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
